@@ rtl/acm_pkg.sv @@
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

  localparam int REQ_W       = 2;
  localparam int SYM_W       = 5;
  localparam int CNT_W       = 11;
  localparam int TOTAL_MAX   = 2047;
  localparam int NODES_DEF   = 1024;
  localparam int ALPHA_DEF   = 26;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_BUILD   = 2'd2,
    REQ_TEXT    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_INSERT,
    OP_BUILD,
    OP_MATCH
  } op_e;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_END  = 2'd1,
    MARK_SEEN = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_MT_RD,
    S_WALK,
    S_B_HEAD,
    S_B_CUR,
    S_B_FAIL,
    S_B_K
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic             last;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/acm_front.sv @@
// ----------------------------------------------------------------------------
// acm_front
// Accepts request beats, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_front #(
  parameter int ALPHABET = acm_pkg::ALPHA_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [acm_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [acm_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic                       last_i,
  input  wire logic                       pop_i,
  output logic                            avail_o,
  output acm_pkg::item_t                  item_o
);

  localparam int PW = $clog2(acm_pkg::QUEUE_DEPTH);

  acm_pkg::item_t            mem_q [acm_pkg::QUEUE_DEPTH];
  acm_pkg::item_t            item_c;
  logic [PW-1:0]             wptr_q, rptr_q;
  logic [PW:0]               cnt_q;
  logic                      push, in_rng;

  assign in_rng     = {4'd0, symbol_i} < 9'(ALPHABET);
  assign in_stall_o = (cnt_q == (PW+1)'(acm_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign avail_o    = (cnt_q != '0);
  assign item_o     = mem_q[rptr_q];

  always_comb begin
    item_c.sym  = symbol_i;
    item_c.last = last_i;
    unique case (acm_pkg::req_e'(req_type_i))
      acm_pkg::REQ_CLEAR:   item_c.op = acm_pkg::OP_CLEAR;
      acm_pkg::REQ_BUILD:   item_c.op = acm_pkg::OP_BUILD;
      acm_pkg::REQ_PATTERN: item_c.op = in_rng ? acm_pkg::OP_INSERT : acm_pkg::OP_NOP;
      acm_pkg::REQ_TEXT:    item_c.op = in_rng ? acm_pkg::OP_MATCH : acm_pkg::OP_NOP;
      default:              item_c.op = acm_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push)  wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/acm_engine.sv @@
// ----------------------------------------------------------------------------
// acm_engine
// Trie insert, link build walk and text matching over the automaton memories.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_engine #(
  parameter int NODES    = acm_pkg::NODES_DEF,
  parameter int ALPHABET = acm_pkg::ALPHA_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       avail_i,
  input  wire acm_pkg::item_t             item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            status_o,
  output logic [acm_pkg::CNT_W-1:0]       new_matches_o,
  output logic [acm_pkg::CNT_W-1:0]       total_matches_o,
  output logic                            done_res_o
);

  localparam int NW = $clog2(NODES);
  localparam int KW = $clog2(ALPHABET);
  localparam int GD = NODES * ALPHABET;
  localparam int AW = $clog2(GD);
  localparam int CW = acm_pkg::CNT_W;

  // memories
  logic [NW-1:0] goto_mem [GD];
  logic [NW-1:0] fail_mem [NODES];
  logic [1:0]    mark_mem [NODES];
  logic [NW-1:0] bfs_mem  [NODES];

  logic [NW-1:0] ga_rd_q, gb_rd_q, fl_rd_q, bq_rd_q;
  logic [1:0]    mk_rd_q;

  logic          g_we, f_we, m_we, b_we;
  logic [AW-1:0] g_waddr, ga_addr, gb_addr;
  logic [NW-1:0] g_wdata, f_waddr, f_wdata, m_waddr, b_waddr, b_wdata, fm_raddr, b_raddr;
  logic [1:0]    m_wdata;

  // state
  acm_pkg::state_e state_q, state_d;
  logic [NW:0]   node_cnt_q, node_cnt_d;
  logic [NW-1:0] ins_cur_q, ins_cur_d, mat_cur_q, mat_cur_d;
  logic [CW-1:0] total_q, total_d, fresh_q, fresh_d;
  logic          linked_q, linked_d, drop_q, drop_d, rsp_q, rsp_d;
  logic          st_q, st_d, dn_q, dn_d, last_q, last_d;
  logic [KW-1:0] k_q, k_d;
  logic [AW-1:0] base_q, base_d, fbase_q, fbase_d, addr_q, addr_d;
  logic [NW-1:0] cur_q, cur_d, t_q, t_d;
  logic [NW:0]   guard_q, guard_d, head_q, head_d, tail_q, tail_d;
  logic          fin;

  // shared decode
  logic          go, k_end, is_full, nxt_zero, child_ok, mk_seen, walk_stop;
  logic [KW-1:0] isym;
  logic [AW-1:0] slot_c, fbase_c;
  logic [NW-1:0] m_c, fcur_c, tn_c, new_c;
  logic [NW:0]   guard_inc;

  assign go        = avail_i && !out_valid_o;
  assign isym      = KW'(item_i.sym);
  assign k_end     = (k_q == KW'(ALPHABET - 1));
  assign is_full   = (node_cnt_q == (NW+1)'(NODES));
  assign nxt_zero  = (ga_rd_q == '0);
  assign new_c     = node_cnt_q[NW-1:0];
  assign m_c       = ({1'b0, ga_rd_q} >= node_cnt_q) ? '0 : ga_rd_q;
  assign fcur_c    = (cur_q == '0) ? '0 : fl_rd_q;
  assign fbase_c   = AW'(fcur_c) * AW'(ALPHABET);
  assign child_ok  = (ga_rd_q != '0) && ({1'b0, ga_rd_q} < node_cnt_q);
  assign mk_seen   = (mk_rd_q == acm_pkg::MARK_SEEN);
  assign tn_c      = ({1'b0, fl_rd_q} >= node_cnt_q) ? '0 : fl_rd_q;
  assign guard_inc = guard_q + 1'b1;
  assign walk_stop = (tn_c == '0) || (tn_c == t_q) || (guard_inc >= (NW+1)'(NODES));

  always_comb begin
    if (item_i.op == acm_pkg::OP_MATCH) slot_c = AW'(mat_cur_q) * AW'(ALPHABET) + AW'(isym);
    else                                slot_c = AW'(ins_cur_q) * AW'(ALPHABET) + AW'(isym);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acm_pkg::S_INIT: if (k_end) state_d = acm_pkg::S_IDLE;
      acm_pkg::S_IDLE: begin
        if (go) begin
          unique case (item_i.op)
            acm_pkg::OP_CLEAR:  state_d = acm_pkg::S_INIT;
            acm_pkg::OP_BUILD:  if (!linked_q) state_d = acm_pkg::S_B_HEAD;
            acm_pkg::OP_INSERT: if (!linked_q && !drop_q) state_d = acm_pkg::S_INS_RD;
            acm_pkg::OP_MATCH:  state_d = acm_pkg::S_MT_RD;
            default:            state_d = acm_pkg::S_IDLE;
          endcase
        end
      end
      acm_pkg::S_INS_RD: state_d = (nxt_zero && !is_full) ? acm_pkg::S_INIT : acm_pkg::S_IDLE;
      acm_pkg::S_MT_RD:  state_d = (m_c == '0) ? acm_pkg::S_IDLE : acm_pkg::S_WALK;
      acm_pkg::S_WALK:   if (mk_seen || walk_stop) state_d = acm_pkg::S_IDLE;
      acm_pkg::S_B_HEAD: state_d = (head_q == tail_q) ? acm_pkg::S_IDLE : acm_pkg::S_B_CUR;
      acm_pkg::S_B_CUR:  state_d = acm_pkg::S_B_FAIL;
      acm_pkg::S_B_FAIL: state_d = acm_pkg::S_B_K;
      acm_pkg::S_B_K:    if (k_end) state_d = acm_pkg::S_B_HEAD;
      default:           state_d = acm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    node_cnt_d = node_cnt_q;  ins_cur_d = ins_cur_q;  mat_cur_d = mat_cur_q;
    total_d    = total_q;     fresh_d   = fresh_q;    linked_d  = linked_q;
    drop_d     = drop_q;      rsp_d     = rsp_q;      st_d      = st_q;
    dn_d       = dn_q;        last_d    = last_q;
    k_d        = k_q;         base_d    = base_q;     fbase_d   = fbase_q;
    addr_d     = addr_q;      cur_d     = cur_q;      t_d       = t_q;
    guard_d    = guard_q;     head_d    = head_q;     tail_d    = tail_q;
    fin        = 1'b0;        pop_o     = 1'b0;
    g_we = 1'b0; g_waddr = base_q + AW'(k_q); g_wdata = '0;
    f_we = 1'b0; f_waddr = new_c;             f_wdata = '0;
    m_we = 1'b0; m_waddr = new_c;             m_wdata = acm_pkg::MARK_NONE;
    b_we = 1'b0; b_waddr = tail_q[NW-1:0];    b_wdata = ga_rd_q;
    ga_addr  = base_q + AW'(k_q) + 1'b1;
    gb_addr  = fbase_q + AW'(k_q) + 1'b1;
    fm_raddr = tn_c;
    b_raddr  = head_q[NW-1:0];

    unique case (state_q)
      acm_pkg::S_INIT: begin
        g_we = 1'b1;
        k_d  = k_q + 1'b1;
        if (k_end) begin
          k_d = '0;
          fin = rsp_q;
        end
      end
      acm_pkg::S_IDLE: begin
        ga_addr = slot_c;
        if (go) begin
          pop_o   = 1'b1;
          addr_d  = slot_c;
          last_d  = item_i.last;
          fresh_d = '0;
          st_d    = 1'b0;
          dn_d    = 1'b0;
          unique case (item_i.op)
            acm_pkg::OP_CLEAR: begin
              node_cnt_d = (NW+1)'(1);
              ins_cur_d = '0; mat_cur_d = '0; total_d = '0;
              linked_d = 1'b0; drop_d = 1'b0;
              base_d = '0; k_d = '0; rsp_d = 1'b1;
            end
            acm_pkg::OP_BUILD: begin
              if (linked_q) begin
                fin = 1'b1;
              end else begin
                b_we = 1'b1; b_waddr = '0; b_wdata = '0;
                head_d = '0; tail_d = (NW+1)'(1);
              end
            end
            acm_pkg::OP_INSERT: begin
              dn_d = item_i.last;
              if (linked_q) begin
                st_d = 1'b1; fin = 1'b1;
              end else if (drop_q) begin
                st_d = 1'b1; fin = 1'b1;
                if (item_i.last) begin
                  drop_d = 1'b0; ins_cur_d = '0;
                end
              end
            end
            acm_pkg::OP_MATCH: dn_d = item_i.last;
            default:           fin  = 1'b1;
          endcase
        end
      end
      acm_pkg::S_INS_RD: begin
        if (nxt_zero && is_full) begin
          st_d = 1'b1; fin = 1'b1;
          if (last_q) ins_cur_d = '0;
          else        drop_d = 1'b1;
        end else if (nxt_zero) begin
          g_we = 1'b1; g_waddr = addr_q; g_wdata = new_c;
          f_we = 1'b1; f_waddr = new_c;  f_wdata = '0;
          m_we = 1'b1; m_waddr = new_c;
          m_wdata = last_q ? acm_pkg::MARK_END : acm_pkg::MARK_NONE;
          node_cnt_d = node_cnt_q + 1'b1;
          ins_cur_d  = last_q ? '0 : new_c;
          base_d     = AW'(new_c) * AW'(ALPHABET);
          k_d = '0; rsp_d = 1'b1;
        end else begin
          fin = 1'b1;
          ins_cur_d = last_q ? '0 : ga_rd_q;
          if (last_q) begin
            m_we = 1'b1; m_waddr = ga_rd_q; m_wdata = acm_pkg::MARK_END;
          end
        end
      end
      acm_pkg::S_MT_RD: begin
        mat_cur_d = last_q ? '0 : m_c;
        t_d       = m_c;
        fm_raddr  = m_c;
        guard_d   = '0;
        if (m_c == '0) fin = 1'b1;
      end
      acm_pkg::S_WALK: begin
        if (mk_seen) begin
          fin = 1'b1;
        end else begin
          if (mk_rd_q == acm_pkg::MARK_END) begin
            fresh_d = fresh_q + 1'b1;
            if (total_q < CW'(acm_pkg::TOTAL_MAX)) total_d = total_q + 1'b1;
          end
          m_we = 1'b1; m_waddr = t_q; m_wdata = acm_pkg::MARK_SEEN;
          guard_d = guard_inc;
          t_d     = tn_c;
          fin     = walk_stop;
        end
      end
      acm_pkg::S_B_HEAD: begin
        if (head_q == tail_q) begin
          linked_d = 1'b1; fin = 1'b1;
        end
      end
      acm_pkg::S_B_CUR: begin
        cur_d    = bq_rd_q;
        head_d   = head_q + 1'b1;
        fm_raddr = bq_rd_q;
        base_d   = AW'(bq_rd_q) * AW'(ALPHABET);
      end
      acm_pkg::S_B_FAIL: begin
        ga_addr = base_q;
        gb_addr = fbase_c;
        fbase_d = fbase_c;
        k_d     = '0;
      end
      acm_pkg::S_B_K: begin
        if (child_ok) begin
          f_we = 1'b1; f_waddr = ga_rd_q;
          f_wdata = (cur_q == '0) ? '0 : gb_rd_q;
          if (tail_q < (NW+1)'(NODES)) begin
            b_we = 1'b1; tail_d = tail_q + 1'b1;
          end
        end else if (cur_q != '0) begin
          g_we = 1'b1; g_wdata = gb_rd_q;
        end
        k_d = k_end ? '0 : k_q + 1'b1;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (g_we) goto_mem[g_waddr] <= g_wdata;
    ga_rd_q <= goto_mem[ga_addr];
    gb_rd_q <= goto_mem[gb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    fl_rd_q <= fail_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mark_mem[m_waddr] <= m_wdata;
    mk_rd_q <= mark_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bfs_mem[b_waddr] <= b_wdata;
    bq_rd_q <= bfs_mem[b_raddr];
  end

  // payload-only registers
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;  addr_q  <= addr_d;
    fbase_q <= fbase_d; cur_q   <= cur_d;   t_q     <= t_d;
    guard_q <= guard_d; fresh_q <= fresh_d; st_q    <= st_d;
    dn_q    <= dn_d;
    if (fin) begin
      status_o        <= st_d;
      new_matches_o   <= fresh_d;
      total_matches_o <= total_d;
      done_res_o      <= dn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= acm_pkg::S_INIT;
      node_cnt_q <= (NW+1)'(1);
      ins_cur_q  <= '0;
      mat_cur_q  <= '0;
      total_q    <= '0;
      linked_q   <= 1'b0;
      drop_q     <= 1'b0;
      rsp_q      <= 1'b0;
      k_q        <= '0;
      base_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      node_cnt_q <= node_cnt_d;
      ins_cur_q  <= ins_cur_d;
      mat_cur_q  <= mat_cur_d;
      total_q    <= total_d;
      linked_q   <= linked_d;
      drop_q     <= drop_d;
      rsp_q      <= (state_q == acm_pkg::S_INIT && k_end) ? 1'b0 : rsp_d;
      k_q        <= k_d;
      base_q     <= base_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      if (fin)                           out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/aho_corasick_matcher_top.sv @@
// ----------------------------------------------------------------------------
// aho_corasick_matcher_top
// Multi-pattern string matcher: request decode queue plus automaton engine.
// ----------------------------------------------------------------------------
// Steps: a text symbol reads its goto slot, then walks the failure chain
//   node by node; a new trie node, and clear for the root, zero a goto
//   row via the single goto write port; build walks every node's symbols.
// Throughput: one beat per engine run, no overlap; the 2-deep request
//   queue keeps taking beats while the engine or the result register waits.
// Reset: async active low; the engine then zeroes the root goto row
//   before it takes the first queued beat.
`default_nettype none

module aho_corasick_matcher_top #(
  parameter int NODES    = acm_pkg::NODES_DEF,
  parameter int ALPHABET = acm_pkg::ALPHA_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [acm_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [acm_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic                       last_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            status_o,
  output logic [acm_pkg::CNT_W-1:0]       new_matches_o,
  output logic [acm_pkg::CNT_W-1:0]       total_matches_o,
  output logic                            done_res_o
);

  // front to back queue interface
  acm_pkg::item_t item;
  logic           avail, pop;

  acm_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .symbol_i   (symbol_i),
    .last_i     (last_i),
    .pop_i      (pop),
    .avail_o    (avail),
    .item_o     (item)
  );

  // engine owns the goto, fail, mark and walk-queue memories
  acm_engine #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .item_i          (item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .new_matches_o   (new_matches_o),
    .total_matches_o (total_matches_o),
    .done_res_o      (done_res_o)
  );

endmodule

`default_nettype wire

@@ rtl/acm_checker.sv @@
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks on the matcher's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       status_o,
  input wire logic [acm_pkg::CNT_W-1:0]  new_matches_o,
  input wire logic [acm_pkg::CNT_W-1:0]  total_matches_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(total_matches_o))
    else $error("stalled total changed");

  a_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_matches_o <= total_matches_o)
    else $error("new matches exceed total");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> new_matches_o == '0)
    else $error("dropped insert reports matches");

endmodule

bind aho_corasick_matcher_top acm_checker u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .new_matches_o   (new_matches_o),
  .total_matches_o (total_matches_o)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed beats into the multi-pattern string matcher. A local
// trie/automaton predictor produces one expected result per request beat;
// the monitor compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int NODE_CAP  = 1024;
  localparam int ALPHA     = 26;
  localparam int IDLE_LIM  = 150000;

  typedef struct packed {
    logic [1:0] req;
    logic [4:0] sym;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic        status;
    logic [10:0] fresh;
    logic [10:0] total;
    logic        done;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] req_type_i = '0;
  logic [4:0] symbol_i = '0;
  logic last_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, status_o, done_res_o;
  logic [10:0] new_matches_o, total_matches_o;

  aho_corasick_matcher_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .symbol_i,
    .last_i, .out_valid_o, .out_stall_i, .status_o, .new_matches_o,
    .total_matches_o, .done_res_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Automaton predictor state
  // --------------------------------------------------------------------------
  logic [9:0]  trie_edge [NODE_CAP*ALPHA];
  logic [9:0]  fail_to [NODE_CAP];
  logic [1:0]  node_mark [NODE_CAP];
  int unsigned nodes_used, ins_at, txt_at, found_cnt;
  bit          links_built, dropping;

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int       err_cnt = 0;
  bit       stim_done = 0;

  function automatic void fresh_node(int unsigned n);
    for (int k = 0; k < ALPHA; k++) trie_edge[n*ALPHA+k] = '0;
    fail_to[n] = '0;
    node_mark[n] = acm_pkg::MARK_NONE;
  endfunction

  function automatic void wipe_automaton();
    nodes_used = 1;
    fresh_node(0);
    ins_at = 0;
    txt_at = 0;
    found_cnt = 0;
    links_built = 0;
    dropping = 0;
  endfunction

  // Breadth-first pass: failure links for trie children, goto fill elsewhere.
  function automatic void link_automaton();
    int unsigned walk[$];
    int unsigned cur, child;
    walk.push_back(0);
    while (walk.size() > 0) begin
      cur = walk.pop_front();
      for (int k = 0; k < ALPHA; k++) begin
        child = trie_edge[cur*ALPHA+k];
        if (child != 0 && child < nodes_used) begin
          fail_to[child] = (cur == 0) ? 10'd0 : trie_edge[fail_to[cur]*ALPHA+k];
          walk.push_back(child);
        end else if (cur != 0) begin
          trie_edge[cur*ALPHA+k] = trie_edge[fail_to[cur]*ALPHA+k];
        end
      end
    end
    links_built = 1;
  endfunction

  function automatic verdict_t match_step(beat_t b);
    verdict_t v;
    int unsigned slot, nxt, t, guard;
    v = '0;
    if (b.req == acm_pkg::REQ_CLEAR) begin
      wipe_automaton();
    end else if (b.req == acm_pkg::REQ_BUILD) begin
      if (!links_built) link_automaton();
    end else if (b.sym < ALPHA) begin
      v.done = b.last;
      if (b.req == acm_pkg::REQ_PATTERN) begin
        if (links_built) begin
          v.status = 1;
        end else if (dropping) begin
          v.status = 1;
          if (b.last) begin
            dropping = 0;
            ins_at = 0;
          end
        end else begin
          slot = ins_at*ALPHA + b.sym;
          nxt = trie_edge[slot];
          if (nxt == 0) begin
            if (nodes_used >= NODE_CAP) begin
              v.status = 1;
              if (b.last) ins_at = 0;
              else dropping = 1;
            end else begin
              nxt = nodes_used;
              trie_edge[slot] = 10'(nxt);
              fresh_node(nxt);
              nodes_used++;
            end
          end
          if (!v.status) begin
            ins_at = nxt;
            if (b.last) begin
              node_mark[ins_at] = acm_pkg::MARK_END;
              ins_at = 0;
            end
          end
        end
      end else begin
        txt_at = trie_edge[txt_at*ALPHA + b.sym];
        if (txt_at >= nodes_used) txt_at = 0;
        t = txt_at;
        guard = 0;
        while (t != 0 && node_mark[t] != acm_pkg::MARK_SEEN && guard < NODE_CAP) begin
          if (node_mark[t] == acm_pkg::MARK_END) begin
            v.fresh++;
            if (found_cnt < acm_pkg::TOTAL_MAX) found_cnt++;
          end
          node_mark[t] = acm_pkg::MARK_SEEN;
          t = fail_to[t];
          if (t >= nodes_used) t = 0;
          guard++;
        end
        if (b.last) txt_at = 0;
      end
    end
    v.total = 11'(found_cnt);
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_beat(logic [1:0] r, logic [4:0] s, logic l);
    beat_t b;
    b.req = r;
    b.sym = s;
    b.last = l;
    pending_beats.push_back(b);
  endfunction

  // Small letter set so texts actually hit patterns.
  function automatic void push_word(logic [1:0] r, int len, int letters);
    for (int i = 0; i < len; i++)
      push_beat(r, 5'($urandom_range(letters-1)), i == len-1);
  endfunction

  initial begin
    int mode;
    wipe_automaton();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, all request kinds, and the special cases.
    push_beat(acm_pkg::REQ_TEXT, 5'd0, 1'b1);       // text before any pattern
    push_beat(acm_pkg::REQ_PATTERN, 5'd0, 1'b0);    // "az"
    push_beat(acm_pkg::REQ_PATTERN, 5'd25, 1'b1);
    push_beat(acm_pkg::REQ_PATTERN, 5'd25, 1'b1);   // "z"
    push_beat(acm_pkg::REQ_PATTERN, 5'd31, 1'b1);   // out of range, ignored
    push_beat(acm_pkg::REQ_TEXT, 5'd0, 1'b0);       // text before build
    push_beat(acm_pkg::REQ_TEXT, 5'd25, 1'b1);
    push_beat(acm_pkg::REQ_PATTERN, 5'd0, 1'b0);    // repeated pattern re-arms
    push_beat(acm_pkg::REQ_PATTERN, 5'd25, 1'b1);
    push_beat(acm_pkg::REQ_BUILD, 5'd31, 1'b1);
    push_beat(acm_pkg::REQ_BUILD, 5'd0, 1'b0);      // repeated build
    push_beat(acm_pkg::REQ_PATTERN, 5'd3, 1'b1);    // insert after build: dropped
    push_beat(acm_pkg::REQ_TEXT, 5'd26, 1'b1);      // out of range text
    push_beat(acm_pkg::REQ_TEXT, 5'd0, 1'b0);
    push_beat(acm_pkg::REQ_TEXT, 5'd25, 1'b1);
    push_beat(acm_pkg::REQ_TEXT, 5'd25, 1'b1);
    push_beat(acm_pkg::REQ_CLEAR, 5'd31, 1'b1);
    push_beat(acm_pkg::REQ_TEXT, 5'd25, 1'b0);

    // Trie full: long patterns of distinct paths fill the 1023 free nodes.
    for (int p = 0; p < 36; p++) push_word(acm_pkg::REQ_PATTERN, 30, 26);
    push_beat(acm_pkg::REQ_PATTERN, 5'd1, 1'b0);    // rest of pattern dropped too
    push_beat(acm_pkg::REQ_PATTERN, 5'd2, 1'b1);
    push_beat(acm_pkg::REQ_BUILD, 5'd0, 1'b0);
    push_word(acm_pkg::REQ_TEXT, 40, 26);
    push_beat(acm_pkg::REQ_CLEAR, 5'd0, 1'b0);

    // Random sessions: patterns, build, texts, with some noise.
    while (pending_beats.size() < 1300) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        push_beat(acm_pkg::REQ_CLEAR, 5'($urandom), 1'($urandom));
      end else if (mode == 9) begin
        push_beat(2'($urandom), 5'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          push_word(acm_pkg::REQ_PATTERN, $urandom_range(1, 4), 4);
        if ($urandom_range(3) != 0)
          push_beat(acm_pkg::REQ_BUILD, 5'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 3))
          push_word(acm_pkg::REQ_TEXT, $urandom_range(1, 12), 4);
      end
    end
    stim_done = 1;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts with random gaps; payload held while stalled.
  // --------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_verdicts.push_back(match_step({req_type_i, symbol_i, last_i}));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          req_type_i <= b.req;
          symbol_i <= b.sym;
          last_i <= b.last;
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern and monitor.
  // --------------------------------------------------------------------------
  int stall_phase = 0;

  always @(posedge clk_i) begin
    verdict_t want;
    stall_phase <= stall_phase + 1;
    // quiet window while bit 9 of the phase is clear, random stalls otherwise
    out_stall_i <= (stall_phase[9]) ? ($urandom_range(2) == 0) : 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (new_matches_o !== want.fresh)
          report_mismatch("new_matches", new_matches_o, want.fresh);
        if (total_matches_o !== want.total)
          report_mismatch("total_matches", total_matches_o, want.total);
        if (done_res_o !== want.done) report_mismatch("done_res", done_res_o, want.done);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog and end of run
  // --------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIM) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_beats.size() == 0 && !in_valid_i);
    wait (expected_verdicts.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/acm_pkg.sv
rtl/acm_front.sv
rtl/acm_engine.sv
rtl/aho_corasick_matcher_top.sv
rtl/acm_checker.sv
tb/testbench.sv
